>>> rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

>>> rtl/core/iabm_pkg.sv
// ----------------------------------------------------------------------------
// iabm_pkg
// Types, codes and helpers for the translation-table bitmap mapper.
// ----------------------------------------------------------------------------
package iabm_pkg;

	localparam logic OP_MAP   = 1'b0;
	localparam logic OP_UNMAP = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_BIG   = 2'd1;
	localparam logic [1:0] ST_NO_RUN    = 2'd2;
	localparam logic [1:0] ST_BAD_UNMAP = 2'd3;

	localparam logic [1:0] CFG_PCIX = 2'd0;
	localparam logic [1:0] CFG_PIC  = 2'd1;
	localparam logic [1:0] CFG_HUB  = 2'd2;

	localparam logic [63:0] DIRECT_BASE = 64'h0000_0000_8000_0000;
	localparam logic [63:0] MAP_WINDOW  = 64'h0000_0000_4000_0000;
	localparam logic [63:0] PT_BAR      = 64'd1 << 56;
	localparam logic [63:0] PT_PREFETCH = 64'd1 << 59;
	localparam logic [63:0] PT_MEM      = 64'd1 << 60;
	localparam logic [63:0] ATE_VALID   = 64'd1;
	localparam logic [63:0] ATE_PREF    = 64'd1 << 3;
	localparam logic [63:0] ATE_BAR     = 64'd1 << 4;
	localparam int          MAX_PAGES   = 64;

	typedef struct packed {
		logic       found;
		logic [5:0] pos;
	} fit_res_t;

	// ones in the low c bits, all ones from 64 up
	function automatic logic [63:0] run_mask(input logic [6:0] c);
		logic [63:0] m;
		if (c >= 7'd64) begin
			m = '1;
		end else begin
			m = (64'd1 << c) - 64'd1;
		end
		return m;
	endfunction

endpackage

>>> rtl/core/iabm_ram.sv
// ----------------------------------------------------------------------------
// iabm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module iabm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/iabm_fit.sv
// ----------------------------------------------------------------------------
// iabm_fit
// First-fit search for a free run of entries inside one bitmap word.
// ----------------------------------------------------------------------------
module iabm_fit (
	input  logic [63:0]        word,
	input  logic [6:0]         count,
	output iabm_pkg::fit_res_t res
);
	import iabm_pkg::*;

	logic [63:0] mask;
	logic [63:0] fits;

	always_comb begin
		mask = run_mask(count);
		for (int s = 0; s < 64; s++) begin
			fits[s] = ((7'(s) + count) <= 7'd64) && (((word >> s) & mask) == 64'd0);
		end
		// a full word never fits, not even an empty run
		res.found = (word != '1) && (|fits);
		res.pos   = '0;
		for (int s = 63; s >= 0; s--) begin
			if (fits[s]) begin
				res.pos = 6'(s);
			end
		end
	end

endmodule

>>> rtl/core/iommu_ate_bitmap_mapper.sv
// ----------------------------------------------------------------------------
// iommu_ate_bitmap_mapper
// Maps and unmaps DMA segments: direct window, flagged pass-through, or a
// first-fit run of translation entries tracked in a bitmap RAM.
// ----------------------------------------------------------------------------
//  channel  signals                 direction  moves
//  cfg      cfg_we/index/wdata      in         register write
//  in       in_valid/in_stall       in         one map or unmap request
//  out      out_valid/out_stall     out        one result, last marks the end
//
//  after reset the bitmap RAM is cleared, one word a cycle
//  an item passes a decode step, then a scan of the bitmap words for a table map
//  or a read-modify-write of its bitmap word for a table unmap, then an emit step
//  a page run gives one result per page (up to 64), every other item one
//  out_stall holds the result register; in_stall stays high until the last
//  result is loaded
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iommu_ate_bitmap_mapper #(
	parameter int ATE_ENTRIES = 1024,
	parameter int PAGE_SHIFT  = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [63:0] bus_addr,
	input  logic [31:0] seg_size,
	input  logic        direct32,
	input  logic        coherent,
	input  logic        full_width_tag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_addr,
	output logic [1:0]  status,
	output logic        entry_write,
	output logic [9:0]  entry_index,
	output logic [63:0] entry_value,
	output logic        last
);
	import iabm_pkg::*;

	localparam int NWORDS = ATE_ENTRIES / 64;
	localparam int WW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int SUMW   = 34;
	localparam int CNTW   = SUMW - PAGE_SHIFT;
	localparam int CW     = 18;
	localparam logic [63:0] PG_SIZE = 64'd1 << PAGE_SHIFT;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_UNMAP  = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;

	logic [2:0]  state_q;
	logic [WW-1:0] word_q;
	logic        pcix_q, pic_q;
	logic [3:0]  hub_q;

	logic        op_q, direct_q, coh_q, fwt_q;
	logic [63:0] ba_q;
	logic [CNTW-1:0] count_q;

	logic [63:0] res_addr_q, val_q;
	logic [1:0]  res_status_q;
	logic        res_wr_q;
	logic [9:0]  idx_q;
	logic [6:0]  rem_q;

	logic        out_valid_q, last_q, wr_o_q;
	logic [63:0] addr_o_q, val_o_q;
	logic [1:0]  status_o_q;
	logic [9:0]  idx_o_q;

	logic        ram_we;
	logic [WW-1:0] ram_waddr, ram_raddr;
	logic [63:0] ram_wdata, ram_rdata;
	fit_res_t    fit;

	logic        can_load, in_xfer;
	logic [SUMW-1:0] pg_sum;
	logic [6:0]  cnt7;
	logic        cnt_big;
	logic [CW-1:0] ue;
	logic [WW-1:0] un_word;
	logic        un_bad;
	logic [WW+5:0] map_entry;
	logic [63:0] map_addr, map_val, pt_addr;
	logic        dec_single, dec_scan, dec_unmap;
	logic [63:0] dec_addr;
	logic [1:0]  dec_status;

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign can_load = !out_valid_q || !out_stall;

	assign pg_sum = SUMW'(bus_addr[PAGE_SHIFT-1:0]) + SUMW'(seg_size)
		+ SUMW'(PG_SIZE - 64'd1);

	assign cnt7    = count_q[6:0];
	assign cnt_big = count_q > CNTW'(MAX_PAGES);
	assign ue      = CW'(ba_q[28:PAGE_SHIFT]);
	assign un_word = ue[6 +: WW];
	assign un_bad  = cnt_big || ((ue + CW'(cnt7)) > CW'(ATE_ENTRIES))
		|| ({1'b0, ue[5:0]} > (7'd64 - cnt7));

	assign map_entry = {word_q, fit.pos};
	assign map_addr  = MAP_WINDOW | 64'(ba_q[PAGE_SHIFT-1:0])
		| (64'(map_entry) << PAGE_SHIFT);
	assign map_val   = {ba_q[63:PAGE_SHIFT], PAGE_SHIFT'(0)} | ATE_VALID
		| (coh_q ? ATE_BAR : (!pcix_q ? ATE_PREF : 64'd0))
		| (pic_q ? (64'(hub_q) << 8) : 64'd0);
	assign pt_addr   = ba_q | (coh_q ? PT_BAR : (!pcix_q ? PT_PREFETCH : 64'd0))
		| (pic_q ? {hub_q, 60'd0} : PT_MEM);

	// path decision for a freshly accepted item
	always_comb begin
		dec_single = 1'b1;
		dec_scan   = 1'b0;
		dec_unmap  = 1'b0;
		dec_addr   = '0;
		dec_status = ST_OK;
		if (op_q == OP_UNMAP) begin
			if (ba_q[63:30] != 34'd1) begin
				dec_status = ST_OK;
			end else if (un_bad) begin
				dec_status = ST_BAD_UNMAP;
			end else if (count_q != '0) begin
				dec_single = 1'b0;
				dec_unmap  = 1'b1;
			end
		end else begin
			if (direct_q && (ba_q[63:31] == 33'd0)) begin
				dec_addr = ba_q | DIRECT_BASE;
			end else if (fwt_q) begin
				dec_addr = pt_addr;
			end else if (cnt_big) begin
				dec_status = ST_TOO_BIG;
			end else begin
				dec_single = 1'b0;
				dec_scan   = 1'b1;
			end
		end
	end

	// bitmap RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = word_q;
		ram_wdata = '0;
		ram_raddr = word_q + WW'(1);
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_DECIDE: begin
				ram_raddr = (op_q == OP_UNMAP) ? un_word : '0;
			end
			S_SCAN: begin
				ram_we    = fit.found;
				ram_wdata = ram_rdata | (run_mask(cnt7) << fit.pos);
			end
			S_UNMAP: begin
				ram_we    = 1'b1;
				ram_waddr = un_word;
				ram_wdata = ram_rdata & ~(run_mask(cnt7) << ue[5:0]);
			end
			default: begin
			end
		endcase
	end

	iabm_ram #(.WIDTH(64), .DEPTH(NWORDS), .AW(WW)) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	iabm_fit u_fit (
		.word  (ram_rdata),
		.count (cnt7),
		.res   (fit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcix_q <= 1'b0;
			pic_q  <= 1'b1;
			hub_q  <= 4'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PCIX: pcix_q <= cfg_wdata[0];
				CFG_PIC:  pic_q  <= cfg_wdata[0];
				CFG_HUB:  hub_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q     <= operation;
			ba_q     <= bus_addr;
			direct_q <= direct32;
			coh_q    <= coherent;
			fwt_q    <= full_width_tag;
			count_q  <= CNTW'(pg_sum >> PAGE_SHIFT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			word_q       <= '0;
			res_addr_q   <= '0;
			res_status_q <= ST_OK;
			res_wr_q     <= 1'b0;
			idx_q        <= '0;
			val_q        <= '0;
			rem_q        <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					word_q <= word_q + WW'(1);
					if (word_q == WW'(NWORDS - 1)) begin
						word_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					word_q       <= '0;
					res_addr_q   <= dec_addr;
					res_status_q <= dec_status;
					res_wr_q     <= 1'b0;
					idx_q        <= '0;
					val_q        <= '0;
					rem_q        <= 7'd1;
					if (dec_single) begin
						state_q <= S_EMIT;
					end else if (dec_scan) begin
						state_q <= S_SCAN;
					end else if (dec_unmap) begin
						state_q <= S_UNMAP;
					end
				end
				S_SCAN: begin
					if (fit.found) begin
						res_addr_q <= map_addr;
						res_wr_q   <= (cnt7 != 7'd0);
						idx_q      <= (cnt7 != 7'd0) ? 10'(map_entry) : 10'd0;
						val_q      <= (cnt7 != 7'd0) ? map_val : 64'd0;
						rem_q      <= (cnt7 != 7'd0) ? cnt7 : 7'd1;
						state_q    <= S_EMIT;
					end else if (word_q == WW'(NWORDS - 1)) begin
						res_status_q <= ST_NO_RUN;
						state_q      <= S_EMIT;
					end else begin
						word_q <= word_q + WW'(1);
					end
				end
				S_UNMAP: begin
					res_wr_q <= 1'b1;
					idx_q    <= ue[9:0];
					rem_q    <= cnt7;
					state_q  <= S_EMIT;
				end
				S_EMIT: begin
					if (can_load) begin
						rem_q <= rem_q - 7'd1;
						idx_q <= idx_q + 10'd1;
						val_q <= val_q + PG_SIZE;
						if (rem_q == 7'd1) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register, loaded one transfer at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && can_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && can_load) begin
			addr_o_q   <= res_addr_q;
			status_o_q <= res_status_q;
			wr_o_q     <= res_wr_q;
			idx_o_q    <= idx_q;
			val_o_q    <= (op_q == OP_UNMAP) ? 64'd0 : val_q;
			last_q     <= (rem_q == 7'd1);
		end
	end

	assign out_valid   = out_valid_q;
	assign result_addr = addr_o_q;
	assign status      = status_o_q;
	assign entry_write = wr_o_q;
	assign entry_index = idx_o_q;
	assign entry_value = val_o_q;
	assign last        = last_q;

	`ASSERT_CLK(a_run_continues, (out_valid && !out_stall && !last) |=> out_valid,
		"result run broken before last")
	`ASSERT_CLK(a_write_ok, (out_valid && entry_write) |-> (status == ST_OK),
		"entry write carries an error status")
	`ASSERT_NEVER(a_no_idle_write, (state_q == S_IDLE) && ram_we,
		"bitmap written while idle")

endmodule
